### sv/batched_execution_throttle_defines.svh
// ----------------------------------------------------------------------------
// batched_execution_throttle_defines
// assertion macros used by the throttle checker
// ----------------------------------------------------------------------------
`ifndef BATCHED_EXECUTION_THROTTLE_DEFINES_SVH
`define BATCHED_EXECUTION_THROTTLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BET_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("throttle check failed");

// next-cycle implication, disabled during reset
`define BET_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("throttle check failed");

// same-cycle implication that stays live through reset
`define BET_ASSERT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |-> (post)) \
      else $error("throttle check failed");

`endif

### sv/bet_pkg.sv
// ----------------------------------------------------------------------------
// bet_pkg
// types, codes and constants of the statement pacing throttle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bet_pkg;

   // default batch size exponent
   localparam int BET_BATCH_LOG2 = 5;

   // field widths
   localparam int MODE_W    = 2;
   localparam int TIME_W    = 32;
   localparam int COUNT_W   = 32;
   localparam int RATE_W    = 24;
   localparam int US_W      = 20;
   localparam int PRODUCT_W = COUNT_W + US_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // microseconds per second
   localparam logic [US_W-1:0] US_PER_SECOND = US_W'(1000000);

   // register reset values
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

   // transaction modes
   localparam logic [MODE_W-1:0] MODE_STATEMENT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ENGAGE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PACE_ALWAYS = 2'd1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TIME_W-1:0] now_us;
   } req_payload_type;

   typedef struct packed {
      logic [TIME_W-1:0]  wait_us;
      logic               checked;
      logic [COUNT_W-1:0] total_count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

### sv/bet_divider.sv
// ----------------------------------------------------------------------------
// bet_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bet_divider
   import bet_pkg::*;
#(
   parameter int DIVIDEND_W = PRODUCT_W,
   parameter int DIVISOR_W  = RATE_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W+1:0]  diff;
   logic                  borrow;

   // one trial subtraction per step
   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff   = {1'b0, trial} - {2'b00, dsr_ff};
      borrow = diff[DIVISOR_W+1];
   end

   // step sequencing
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dsr_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = borrow ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], ~borrow};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      quo_ff   <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/batched_execution_throttle.sv
// sequence: a transaction that closes no batch goes from idle to finish; a
//    batch check runs through the multiply, start, divider and finish states
// throughput: one transaction at a time; a batch check waits on the 52-step divider
// reset: synchronous, active high; clears counters, window and engaged flag,
//    sets target_rate to 1000 and pace_always to 0
// ----------------------------------------------------------------------------
// batched_execution_throttle
// paces executed statements to a target rate and reports wait times
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module batched_execution_throttle
   import bet_pkg::*;
#(
   parameter int BATCH_LOG2 = BET_BATCH_LOG2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [COUNT_W-1:0] BATCH_MASK = COUNT_W'((64'd1 << BATCH_LOG2) - 64'd1);

   state_type              state_ff, state_in;
   logic [RATE_W-1:0]      rate_ff;
   logic                   pace_always_ff;
   logic [COUNT_W-1:0]     batch_count_ff, batch_count_in;
   logic [TIME_W-1:0]      window_start_ff, window_start_in;
   logic                   engaged_ff, engaged_in;
   logic [COUNT_W-1:0]     total_ff, total_in;
   logic [TIME_W-1:0]      elapsed_ff, elapsed_in;
   logic                   checked_ff, checked_in;
   logic [PRODUCT_W-1:0]   product_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   req_take;
   logic                   rsp_free;
   logic                   pacing;
   logic                   div_start;
   logic                   div_done;
   logic [PRODUCT_W-1:0]   quotient;
   logic [PRODUCT_W:0]     wait_diff;
   logic [TIME_W-1:0]      wait_value;

   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign pacing    = (rate_ff != '0) && (pace_always_ff || engaged_ff);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff        <= RATE_RESET;
         pace_always_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TARGET_RATE) begin
            rate_ff <= csr_wdata[RATE_W-1:0];
         end
         if (csr_index == CSR_PACE_ALWAYS) begin
            pace_always_ff <= csr_wdata[0];
         end
      end
   end

   // per-transaction state update at accept
   always_comb begin
      batch_count_in  = batch_count_ff;
      window_start_in = window_start_ff;
      engaged_in      = engaged_ff;
      total_in        = total_ff;
      elapsed_in      = elapsed_ff;
      checked_in      = checked_ff;
      if (req_take) begin
         checked_in = 1'b0;
         elapsed_in = req_data.now_us - window_start_ff;
         unique case (req_data.mode)
            MODE_STATEMENT: begin
               total_in = total_ff + 1'b1;
               if (pacing) begin
                  batch_count_in = batch_count_ff + 1'b1;
                  checked_in     = ((batch_count_in & BATCH_MASK) == '0);
               end
            end
            MODE_ENGAGE: begin
               if (!engaged_ff) begin
                  engaged_in      = 1'b1;
                  batch_count_in  = '0;
                  window_start_in = req_data.now_us;
               end
            end
            MODE_RESTART: begin
               batch_count_in  = '0;
               window_start_in = req_data.now_us;
               engaged_in      = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_count_ff  <= '0;
         window_start_ff <= '0;
         engaged_ff      <= 1'b0;
         total_ff        <= '0;
      end else begin
         batch_count_ff  <= batch_count_in;
         window_start_ff <= window_start_in;
         engaged_ff      <= engaged_in;
         total_ff        <= total_in;
      end
   end

   // transaction scratch registers and expected-time product
   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      checked_ff <= checked_in;
      if (state_ff == ST_MUL) begin
         product_ff <= batch_count_ff * US_PER_SECOND;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = checked_in ? ST_MUL : ST_FINISH;
            end
         end
         ST_MUL:   state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_START: div_start = 1'b1;
         default: begin
         end
      endcase
   end

   bet_divider #(
      .DIVIDEND_W (PRODUCT_W),
      .DIVISOR_W  (RATE_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (rate_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // expected minus elapsed, saturated
   always_comb begin
      wait_diff = {1'b0, quotient} - {{(PRODUCT_W - TIME_W + 1){1'b0}}, elapsed_ff};
      if (!checked_ff || wait_diff[PRODUCT_W]) begin
         wait_value = '0;
      end else if (wait_diff[PRODUCT_W-1:TIME_W] != '0) begin
         wait_value = '1;
      end else begin
         wait_value = wait_diff[TIME_W-1:0];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.wait_us     = wait_value;
         rsp_data_in.checked     = checked_ff;
         rsp_data_in.total_count = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/bet_checker.sv
// ----------------------------------------------------------------------------
// bet_checker
// port-level checks of the statement pacing throttle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "batched_execution_throttle_defines.svh"

module bet_checker
   import bet_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_payload_type       rsp_data
);

   // a stalled result holds
   `BET_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // the block is busy right after it takes a transaction
   `BET_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)

   // an unchecked result carries no wait
   `BET_ASSERT_NOW(a_wait_needs_check, clock, reset, rsp_valid && !rsp_data.checked, rsp_data.wait_us == '0)

   // no result is pending right after reset
   `BET_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_valid)

endmodule

bind batched_execution_throttle bet_checker u_bet_checker (.*);

### tb/tb_batched_execution_throttle.sv
// ----------------------------------------------------------------------------
// tb_batched_execution_throttle
// self-checking bench for the statement pacing throttle: a short table of
// hand-checked transactions, then randomized pacing runs at many rates; the
// other results are compared against a cycle-free model of the pacing arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_batched_execution_throttle;
   import bet_pkg::*;

   localparam int BATCH_LOG2 = BET_BATCH_LOG2;
   localparam int TOTAL_ITEMS = 1050;
   localparam int QUIET_TAIL = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_MAX = 10;

   // mode and register index the block leaves unused
   localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      req_payload_type       item;
      bit                    typed;
      rsp_payload_type       want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // pacing model state
   logic [RATE_W-1:0]  rate_r;
   logic               always_r;
   logic [COUNT_W-1:0] batch_r;
   logic [TIME_W-1:0]  window_r;
   logic               engaged_r;
   logic [COUNT_W-1:0] total_r;

   rsp_payload_type due_results[$];
   plan_row_type    plan[$];

   int  fail_count = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  checks_seen = 0;
   int  waits_seen = 0;
   int  settings_used = 0;
   int  cycles = 0;
   int  hold_left = 0;
   int  burst_left = 0;
   bit  hold_req = 1'b0;
   bit  tx_idle_on = 1'b1;
   bit  rx_idle_on = 1'b1;
   bit  req_up = 1'b0;
   bit  csr_up = 1'b0;

   batched_execution_throttle dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // advance the pacing model by one transaction and return its result
   function automatic rsp_payload_type pace_step(input req_payload_type r);
      rsp_payload_type o;
      logic [TIME_W-1:0] span_us;
      logic [63:0]       due_us;
      logic [63:0]       slack_us;
      o = '0;
      case (r.mode)
         MODE_STATEMENT: begin
            total_r = total_r + 1'b1;
            if (rate_r != '0 && (always_r || engaged_r)) begin
               batch_r = batch_r + 1'b1;
               if (batch_r[BATCH_LOG2-1:0] == '0) begin
                  o.checked = 1'b1;
                  // exact integer form of count * 1e6 / rate
                  due_us = (64'(batch_r) * 64'(US_PER_SECOND)) / 64'(rate_r);
                  span_us = r.now_us - window_r;
                  if (due_us > 64'(span_us)) begin
                     slack_us = due_us - 64'(span_us);
                     o.wait_us = (slack_us > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                            : slack_us[31:0];
                  end
               end
            end
         end
         MODE_ENGAGE: begin
            if (!engaged_r) begin
               engaged_r = 1'b1;
               batch_r = '0;
               window_r = r.now_us;
            end
         end
         MODE_RESTART: begin
            batch_r = '0;
            window_r = r.now_us;
            engaged_r = 1'b0;
         end
         default: ;
      endcase
      o.total_count = total_r;
      return o;
   endfunction

   // directed table rows
   function automatic void add_item(input logic [MODE_W-1:0] mode,
                                    input logic [TIME_W-1:0] now_us);
      plan_row_type row;
      row = '{default: '0};
      row.item.mode = mode;
      row.item.now_us = now_us;
      plan.push_back(row);
   endfunction

   // row whose result is plain: no wait, no check, the given total
   function automatic void add_typed(input logic [MODE_W-1:0] mode,
                                     input logic [TIME_W-1:0] now_us,
                                     input logic [COUNT_W-1:0] total);
      plan_row_type row;
      row = '{default: '0};
      row.item.mode = mode;
      row.item.now_us = now_us;
      row.typed = 1'b1;
      row.want.total_count = total;
      plan.push_back(row);
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      plan.push_back(row);
   endfunction

   // offer one transaction and record what it must produce
   task automatic send_item(input req_payload_type p, input bit typed,
                            input rsp_payload_type want);
      rsp_payload_type predicted;
      if (csr_up) begin
         csr_valid <= 1'b0;
         csr_up = 1'b0;
      end
      if (tx_idle_on && items_sent + QUIET_TAIL < TOTAL_ITEMS
          && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      req_up = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = pace_step(p);
      due_results.push_back(typed ? want : predicted);
      if (p.mode != MODE_UNUSED) items_sent++;
   endtask

   // stop offering and let every outstanding result come back
   task automatic drain();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // register write, valid stays up for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      csr_up = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TARGET_RATE: rate_r = val[RATE_W-1:0];
         CSR_PACE_ALWAYS: always_r = val[0];
         default: ;
      endcase
   endtask

   // one pacing run: new settings, window restart, batches of statements
   task automatic random_phase(input int phase_no);
      logic [RATE_W-1:0]     rate;
      logic [CSR_DATA_W-1:0] word;
      logic [TIME_W-1:0]     clk_us;
      req_payload_type       p;
      rsp_payload_type       none;
      int unsigned           nominal;
      int unsigned           step;
      int                    pick;
      int                    tempo;
      int                    stmts;
      none = '0;
      pick = (phase_no < 3) ? phase_no : $urandom_range(0, 9);
      case (pick)
         0:       rate = RATE_W'(1);
         1:       rate = '1;
         2:       rate = '0;
         3, 4:    rate = RATE_W'($urandom_range(2, 100));
         5, 6, 7: rate = RATE_W'($urandom_range(100, 100000));
         default: rate = RATE_W'($urandom);
      endcase
      drain();
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      word = $urandom;
      word[RATE_W-1:0] = rate;
      write_reg(CSR_TARGET_RATE, word);
      write_reg(CSR_PACE_ALWAYS, $urandom);
      settings_used++;

      // time base, sometimes just short of the 32-bit wrap
      if ($urandom_range(0, 3) == 0)
         clk_us = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 1000000));
      else
         clk_us = $urandom;
      nominal = (rate == '0) ? $urandom_range(1, 5000) : 1000000 / rate;
      tempo = $urandom_range(0, 2);

      p.mode = MODE_RESTART;
      p.now_us = clk_us;
      send_item(p, 1'b0, none);
      if (!always_r || $urandom_range(0, 1) == 0) begin
         clk_us = clk_us + TIME_W'($urandom_range(0, 50));
         p.mode = MODE_ENGAGE;
         p.now_us = clk_us;
         send_item(p, 1'b0, none);
      end

      stmts = 32 * $urandom_range(1, 3) + $urandom_range(0, 31);
      if (stmts > TOTAL_ITEMS - items_sent) stmts = TOTAL_ITEMS - items_sent;
      for (int i = 0; i < stmts; i++) begin
         if (phase_no == 3 && i == 8) hold_req = 1'b1;
         case (tempo)
            0:       step = $urandom_range(0, nominal);
            1:       step = $urandom_range(0, 2 * nominal + 1);
            default: step = $urandom_range(nominal, 3 * nominal + 1);
         endcase
         clk_us = clk_us + TIME_W'(step);
         p.mode = MODE_STATEMENT;
         p.now_us = clk_us;
         // occasional stray or out-of-order transaction
         if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 4))
               0: begin
                  p.mode = MODE_UNUSED;
                  p.now_us = $urandom;
               end
               1: p.mode = MODE_ENGAGE;
               2: p.mode = MODE_RESTART;
               3: p.now_us = $urandom;
               default: begin
                  p.mode = MODE_W'($urandom);
                  p.now_us = $urandom;
               end
            endcase
         end
         send_item(p, 1'b0, none);
      end
   endtask

   // result side: compare each transaction, then pick the next stall
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_data.checked) begin
               checks_seen++;
               if (rsp_data.wait_us != '0) waits_seen++;
            end
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected result: wait_us %0d checked %0d total_count %0d",
                           rsp_data.wait_us, rsp_data.checked, rsp_data.total_count);
            end else begin
               want = due_results.pop_front();
               if (rsp_data.wait_us !== want.wait_us
                   || rsp_data.checked !== want.checked
                   || rsp_data.total_count !== want.total_count) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display({"mismatch: wait_us exp %0d got %0d, ",
                               "checked exp %0d got %0d, total_count exp %0d got %0d"},
                              want.wait_us, rsp_data.wait_us, want.checked, rsp_data.checked,
                              want.total_count, rsp_data.total_count);
               end
            end
         end

         // long hold-off on request, otherwise random bursts
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (rx_idle_on && items_sent + QUIET_TAIL < TOTAL_ITEMS
                      && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(1, 14) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus
   initial begin
      int phase_no;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      rate_r = RATE_RESET;
      always_r = 1'b0;
      batch_r = '0;
      window_r = '0;
      engaged_r = 1'b0;
      total_r = '0;

      // defaults after reset: rate 1000, not engaged, pace_always clear
      add_typed(MODE_UNUSED,    32'hFFFF_FFFF, 0);
      add_typed(MODE_STATEMENT, 32'h0000_0000, 1);
      add_typed(MODE_STATEMENT, 32'hFFFF_FFFF, 2);
      add_typed(MODE_ENGAGE,    32'h1234_5678, 2);
      add_typed(MODE_ENGAGE,    32'h0000_0000, 2);
      add_typed(MODE_STATEMENT, 32'hAAAA_AAAA, 3);
      add_typed(MODE_RESTART,   32'h5555_5555, 3);
      add_typed(MODE_UNUSED,    32'h0000_0000, 3);
      // zero rate with high bits set in the write data: pacing off
      add_write(CSR_TARGET_RATE, 32'hFF00_0000);
      add_write(CSR_PACE_ALWAYS, 32'hFFFF_FFFE);
      add_typed(MODE_ENGAGE,    32'h0000_0000, 3);
      add_typed(MODE_STATEMENT, 32'h0000_0007, 4);
      // top rate, pace always, write to an unused index
      add_write(CSR_TARGET_RATE, 32'hFFFF_FFFF);
      add_write(CSR_PACE_ALWAYS, 32'h0000_0003);
      add_write(CSR_UNUSED,      32'hFFFF_FFFF);
      add_typed(MODE_RESTART,   32'hFFFF_FFFF, 4);
      add_typed(MODE_STATEMENT, 32'h0000_0000, 5);
      add_typed(MODE_STATEMENT, 32'h8000_0000, 6);
      add_typed(MODE_STATEMENT, 32'hFFFF_FFFF, 7);
      add_typed(MODE_ENGAGE,    32'h0000_0001, 7);
      add_typed(MODE_STATEMENT, 32'h0000_0002, 8);
      // lowest rate, engage required again
      add_write(CSR_TARGET_RATE, 32'h0000_0001);
      add_write(CSR_PACE_ALWAYS, 32'h0000_0000);
      add_typed(MODE_RESTART,   32'h0000_0000, 8);
      add_item(MODE_STATEMENT,  32'h0000_1000);
      add_item(MODE_ENGAGE,     32'h0000_0000);
      add_item(MODE_STATEMENT,  32'h0000_0000);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain();
            write_reg(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            send_item(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      // randomized pacing runs
      phase_no = 0;
      while (items_sent < TOTAL_ITEMS) begin
         random_phase(phase_no);
         phase_no++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d results over %0d rate/mode settings after the directed table",
               results_seen, settings_used);
      $display("%0d batch checks, %0d of them asked for a wait", checks_seen, waits_seen);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d failing results", fail_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
